>>> design/cjs_pkg.sv
// Shared types and constants for the CPU job scheduler simulator.
// No dependencies; imported by the cell and the top level.
`timescale 1ns / 1ps
package cjs_pkg;

  localparam int MAX_JOBS_DEF = 16;
  localparam int TW = 17;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_FCFS = 2'd0,
    MODE_SRTF = 2'd1,
    MODE_PRIO = 2'd2,
    MODE_RR   = 2'd3
  } mode_t;

  typedef enum logic [0:0] {
    REG_MODE    = 1'b0,
    REG_QUANTUM = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_LOAD   = 3'd1,
    OP_RELOAD = 3'd2,
    OP_REM    = 3'd3,
    OP_ADMIT  = 3'd4
  } cell_op_t;

  typedef struct packed {
    logic [15:0]   arrival;
    logic [7:0]    burst;
    logic [7:0]    prio;
    logic [7:0]    rem;
    logic [TW-1:0] fin;
    logic          adm;
  } cell_data_t;

  typedef struct packed {
    cell_op_t      op;
    logic [15:0]   arrival;
    logic [7:0]    burst;
    logic [7:0]    prio;
    logic [7:0]    rem;
    logic [TW-1:0] fin;
  } cell_ctl_t;

endpackage

>>> design/cjs_cell.sv
// One job cell of the rotating job ring.
// Depends on cjs_pkg for the cell data and control structs.
`timescale 1ns / 1ps
module cjs_cell (
  input  logic               clk,
  input  logic               shift,
  input  logic               sel,
  input  cjs_pkg::cell_ctl_t ctl,
  input  cjs_pkg::cell_data_t nb_in,
  output cjs_pkg::cell_data_t data
);
  import cjs_pkg::*;

  always_ff @(posedge clk) begin
    if (shift) begin
      data <= nb_in;
    end else begin
      case (ctl.op)
        OP_LOAD: begin
          if (sel) begin
            data.arrival <= ctl.arrival;
            data.burst   <= ctl.burst;
            data.prio    <= ctl.prio;
          end
        end
        OP_RELOAD: begin
          data.rem <= data.burst;
          data.fin <= '0;
          data.adm <= 1'b0;
        end
        OP_REM: begin
          if (sel) begin
            data.rem <= ctl.rem;
            if (ctl.rem == 8'd0) data.fin <= ctl.fin;
          end
        end
        OP_ADMIT: begin
          if (sel) data.adm <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> design/cpu_job_scheduler_sim.sv
// Top level of the CPU job scheduler simulator: command decode, ring of
// job cells, scan sequencer and ready queue. Depends on cjs_pkg, cjs_cell.
//
// Usage: a request is taken when start is high and busy is low. cmd 0 loads
// a job (ignored when the table is full), cmd 2 clears the table, cmd 1 runs
// the schedule chosen by the mode register; cmd 3 does nothing. Load, clear
// and unused commands complete without raising busy. Configuration writes
// (cfg_index 0 mode, 1 quantum) are always ready; the user must make them
// only while busy is low, and the block itself does not enforce this.
// A run rotates the job ring once per decision: a full ring scan for every
// simulated tick (modes 0 to 2), and in round robin one for each admission
// pass and one to fetch each slice. Results then come one per cycle in load
// order, strobe high for one cycle each, last on the final one; the outputs
// are registered from the emit scan after the final tick, and busy drops when
// that scan ends, in the cycle showing the final result of a full table.
// The receiver cannot stall; results are shown exactly once.
// Reset empties the job table and sets mode 0 and quantum 2.
`timescale 1ns / 1ps
module cpu_job_scheduler_sim #(
  parameter int MAX_JOBS = cjs_pkg::MAX_JOBS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            cmd,
  input  logic [15:0]           arrival,
  input  logic [7:0]            burst,
  input  logic [7:0]            prio,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [0:0]            cfg_index,
  input  logic [7:0]            cfg_data,
  output logic                  strobe,
  output logic [3:0]            job_index,
  output logic [cjs_pkg::TW-1:0] completion,
  output logic [cjs_pkg::TW-1:0] turnaround,
  output logic [cjs_pkg::TW-1:0] waiting,
  output logic                  last
);
  import cjs_pkg::*;

  localparam int IW = $clog2(MAX_JOBS);
  localparam int CW = $clog2(MAX_JOBS + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_TSCAN = 9'b000000010,
    S_TICK  = 9'b000000100,
    S_ASCAN = 9'b000001000,
    S_ADMIT = 9'b000010000,
    S_SLICE = 9'b000100000,
    S_FETCH = 9'b001000000,
    S_RUN   = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  state_t state;
  logic [1:0] mode;
  logic [7:0] quantum;
  logic [CW-1:0] job_count, done_count, ready_count;
  logic [IW-1:0] ptr, best, cur;
  logic [15:0] best_key;
  logic [7:0] best_rem;
  logic best_v, pending_v;
  logic [IW-1:0] pending;
  logic [TW-1:0] t;
  logic [IW-1:0] ready_fifo [MAX_JOBS];

  cell_data_t cells [MAX_JOBS];
  cell_ctl_t ctl;
  logic [MAX_JOBS-1:0] sel;
  logic [IW-1:0] tgt;
  logic shift;
  cell_data_t h;

  logic scan_end, in_range, elig;
  logic [15:0] key;
  logic [7:0] q, run_len, new_rem;
  logic [TW-1:0] tat, wt;
  logic push;
  logic [IW-1:0] push_val;

  assign h = cells[0];
  assign busy = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign scan_end = (ptr == IW'(MAX_JOBS - 1));
  assign in_range = (CW'(ptr) < job_count);
  assign shift = (state == S_TSCAN) || (state == S_ASCAN) ||
                 (state == S_FETCH) || (state == S_EMIT);
  assign q = (quantum == 8'd0) ? 8'd1 : quantum;
  assign run_len = (best_rem > q) ? q : best_rem;
  assign new_rem = best_rem - run_len;

  always_comb begin
    key = 16'd0;
    elig = 1'b0;
    if (state == S_ASCAN) begin
      key = h.arrival;
      elig = in_range && !h.adm && (h.arrival <= 16'(t));
      if (t > TW'(16'hFFFF)) elig = in_range && !h.adm;
    end else begin
      unique case (mode) inside
        MODE_FCFS: key = h.arrival;
        MODE_SRTF: key = {8'd0, h.rem};
        MODE_PRIO, MODE_RR: key = {8'd0, h.prio};
        default: key = h.arrival;
      endcase
      elig = in_range && (h.rem != 8'd0) &&
             ((mode == MODE_PRIO) || (TW'(h.arrival) <= t));
    end
  end

  always_comb begin
    tat = (h.fin > TW'(h.arrival)) ? h.fin - TW'(h.arrival) : '0;
    wt  = (tat > TW'(h.burst)) ? tat - TW'(h.burst) : '0;
  end

  always_comb begin
    ctl = '0;
    ctl.op = OP_NONE;
    tgt = best;
    unique case (state)
      S_IDLE: begin
        tgt = job_count[IW-1:0];
        if (start && (cmd == CMD_LOAD) && (job_count < CW'(MAX_JOBS))) begin
          ctl.op = OP_LOAD;
          ctl.arrival = arrival;
          ctl.burst = (burst == 8'd0) ? 8'd1 : burst;
          ctl.prio = prio;
        end else if (start && (cmd == CMD_RUN)) begin
          ctl.op = OP_RELOAD;
        end
      end
      S_TICK: begin
        if (best_v) begin
          ctl.op = OP_REM;
          ctl.rem = best_rem - 8'd1;
          ctl.fin = t + TW'(1);
        end
      end
      S_ADMIT: begin
        if (best_v) ctl.op = OP_ADMIT;
      end
      S_RUN: begin
        tgt = cur;
        ctl.op = OP_REM;
        ctl.rem = new_rem;
        ctl.fin = t + TW'(run_len);
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < MAX_JOBS; i++) sel[i] = (tgt == IW'(i));
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_JOBS; gi++) begin : g_cell
      localparam int NXT = (gi + 1) % MAX_JOBS;
      cjs_cell u_cell (
        .clk  (clk),
        .shift(shift),
        .sel  (sel[gi]),
        .ctl  (ctl),
        .nb_in(cells[NXT]),
        .data (cells[gi])
      );
    end
  endgenerate

  always_comb begin
    push = 1'b0;
    push_val = best;
    if (state == S_ADMIT) begin
      if (best_v) begin
        push = 1'b1;
      end else if (pending_v) begin
        push = 1'b1;
        push_val = pending;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && (ready_count < CW'(MAX_JOBS))) begin
      for (int i = 0; i < MAX_JOBS; i++) begin
        if (ready_count == CW'(i)) ready_fifo[i] <= push_val;
      end
    end else if ((state == S_SLICE) && (ready_count != '0)) begin
      for (int i = 0; i < MAX_JOBS - 1; i++) ready_fifo[i] <= ready_fifo[i + 1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode <= MODE_FCFS;
      quantum <= 8'd2;
      job_count <= '0;
      ready_count <= '0;
      done_count <= '0;
      ptr <= '0;
      best_v <= 1'b0;
      pending_v <= 1'b0;
      t <= '0;
      strobe <= 1'b0;
      last <= 1'b0;
    end else begin
      strobe <= 1'b0;
      last <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MODE: mode <= cfg_data[1:0];
          REG_QUANTUM: quantum <= cfg_data;
          default: ;
        endcase
      end
      if (shift) ptr <= ptr + IW'(1);
      if (((state == S_TSCAN) || (state == S_ASCAN)) && elig &&
          (!best_v || (key < best_key))) begin
        best_v <= 1'b1;
        best <= ptr;
        best_key <= key;
        best_rem <= h.rem;
      end
      if ((state == S_FETCH) && (ptr == cur)) best_rem <= h.rem;
      if (push && (ready_count < CW'(MAX_JOBS))) ready_count <= ready_count + CW'(1);

      unique case (state)
        S_IDLE: begin
          if (start) begin
            unique case (cmd)
              CMD_LOAD: begin
                if (job_count < CW'(MAX_JOBS)) job_count <= job_count + CW'(1);
              end
              CMD_CLEAR: job_count <= '0;
              CMD_RUN: begin
                ready_count <= '0;
                done_count <= '0;
                pending_v <= 1'b0;
                t <= '0;
                ptr <= '0;
                best_v <= 1'b0;
                if (job_count != '0) state <= (mode == MODE_RR) ? S_ASCAN : S_TSCAN;
              end
              default: ;
            endcase
          end
        end
        S_TSCAN: if (scan_end) state <= S_TICK;
        S_TICK: begin
          t <= t + TW'(1);
          ptr <= '0;
          best_v <= 1'b0;
          if (best_v && (best_rem == 8'd1) && (done_count + CW'(1) == job_count)) begin
            done_count <= done_count + CW'(1);
            state <= S_EMIT;
          end else begin
            if (best_v && (best_rem == 8'd1)) done_count <= done_count + CW'(1);
            state <= S_TSCAN;
          end
        end
        S_ASCAN: if (scan_end) state <= S_ADMIT;
        S_ADMIT: begin
          ptr <= '0;
          best_v <= 1'b0;
          if (best_v) begin
            state <= S_ASCAN;
          end else begin
            pending_v <= 1'b0;
            state <= S_SLICE;
          end
        end
        S_SLICE: begin
          ptr <= '0;
          if (ready_count == '0) begin
            t <= t + TW'(1);
            state <= S_ASCAN;
          end else begin
            cur <= ready_fifo[0];
            ready_count <= ready_count - CW'(1);
            state <= S_FETCH;
          end
        end
        S_FETCH: if (scan_end) state <= S_RUN;
        S_RUN: begin
          t <= t + TW'(run_len);
          ptr <= '0;
          best_v <= 1'b0;
          if (new_rem == 8'd0) begin
            done_count <= done_count + CW'(1);
            state <= (done_count + CW'(1) == job_count) ? S_EMIT : S_ASCAN;
          end else begin
            pending <= cur;
            pending_v <= 1'b1;
            state <= S_ASCAN;
          end
        end
        S_EMIT: begin
          if (in_range) begin
            strobe <= 1'b1;
            last <= (CW'(ptr) + CW'(1) == job_count);
          end
          if (scan_end) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT) begin
      job_index <= 4'(ptr);
      completion <= h.fin;
      turnaround <= tat;
      waiting <= wt;
    end
  end

endmodule

>>> sim/tb_cpu_job_scheduler_sim.sv
// Testbench for the CPU job scheduler simulator: queued loads, clears, runs and
// register writes, checked against an in-bench schedule predictor.
// Depends on cjs_pkg and cpu_job_scheduler_sim.
`timescale 1ns / 1ps
module tb_cpu_job_scheduler_sim;
  import cjs_pkg::*;

  localparam int NJ = 16;
  localparam int WD_LIMIT = 1000000;

  typedef enum int {K_CMD, K_CFG, K_DRAIN} req_kind_t;
  typedef struct {
    req_kind_t   kind;
    cmd_t        c;
    logic [15:0] a;
    logic [7:0]  b;
    logic [7:0]  p;
    reg_idx_t    ri;
    logic [7:0]  d;
  } req_t;
  typedef struct {
    logic [3:0]    idx;
    logic [TW-1:0] comp;
    logic [TW-1:0] tat;
    logic [TW-1:0] wt;
    logic          lst;
  } job_report_t;

  logic clk = 0, rst = 1;
  logic start = 0, cfg_valid = 0;
  logic [1:0] cmd = CMD_NONE;
  logic [15:0] arrival = 0;
  logic [7:0] burst = 0, prio = 0, cfg_data = 0;
  logic [0:0] cfg_index = REG_MODE;
  logic busy, cfg_ready, strobe, last;
  logic [3:0] job_index;
  logic [TW-1:0] completion, turnaround, waiting;

  cpu_job_scheduler_sim dut (.*);

  always #5 clk = ~clk;

  req_t pending_reqs[$];
  job_report_t expected_reports[$];
  int errors = 0, n_runs = 0, n_reports = 0, n_loads = 0, wd = 0;
  bit stim_done = 0;

  // scheduler predictor state
  mode_t p_mode = MODE_FCFS;
  int p_quantum = 2;
  int p_count = 0;
  int p_arr[NJ], p_bst[NJ], p_pri[NJ];

  function automatic void predict_schedule();
    int rem[NJ];
    int fin[NJ];
    bit adm[NJ];
    int rq[$];
    int t, done, j, best, key, bkey, q, slice, pend, tat, wt;
    for (int k = 0; k < p_count; k++) begin
      rem[k] = p_bst[k];
      fin[k] = 0;
      adm[k] = 0;
    end
    t = 0;
    done = 0;
    if (p_mode != MODE_RR) begin
      while (done < p_count) begin
        best = -1;
        bkey = 0;
        for (int k = 0; k < p_count; k++) begin
          if (rem[k] == 0) continue;
          if (p_mode != MODE_PRIO && p_arr[k] > t) continue;
          key = (p_mode == MODE_FCFS) ? p_arr[k] : (p_mode == MODE_SRTF) ? rem[k] : p_pri[k];
          if (best < 0 || key < bkey) begin
            best = k;
            bkey = key;
          end
        end
        t++;
        if (best >= 0) begin
          rem[best]--;
          if (rem[best] == 0) begin
            fin[best] = t;
            done++;
          end
        end
      end
    end else begin
      q = (p_quantum == 0) ? 1 : p_quantum;
      pend = -1;
      while (done < p_count) begin
        forever begin
          best = -1;
          for (int k = 0; k < p_count; k++) begin
            if (adm[k] || p_arr[k] > t) continue;
            if (best < 0 || p_arr[k] < p_arr[best]) best = k;
          end
          if (best < 0) break;
          adm[best] = 1;
          rq = {rq, best};
        end
        if (pend >= 0) rq = {rq, pend};
        pend = -1;
        if (rq.size() == 0) begin
          t++;
          continue;
        end
        j = rq.pop_front();
        slice = (rem[j] > q) ? q : rem[j];
        rem[j] -= slice;
        t += slice;
        if (rem[j] == 0) begin
          fin[j] = t;
          done++;
        end else begin
          pend = j;
        end
      end
    end
    for (int k = 0; k < p_count; k++) begin
      job_report_t r;
      tat = (fin[k] > p_arr[k]) ? fin[k] - p_arr[k] : 0;
      wt = (tat > p_bst[k]) ? tat - p_bst[k] : 0;
      r.idx = k[3:0];
      r.comp = fin[k][TW-1:0];
      r.tat = tat[TW-1:0];
      r.wt = wt[TW-1:0];
      r.lst = (k + 1 == p_count);
      expected_reports = {expected_reports, r};
    end
  endfunction

  function automatic void apply_request(req_t r);
    case (r.c)
      CMD_LOAD: begin
        if (p_count < NJ) begin
          p_arr[p_count] = r.a;
          p_bst[p_count] = (r.b == 0) ? 1 : r.b;
          p_pri[p_count] = r.p;
          p_count++;
        end
        n_loads++;
      end
      CMD_RUN: begin
        predict_schedule();
        n_runs++;
      end
      CMD_CLEAR: p_count = 0;
      default: ;
    endcase
  endfunction

  // driver
  req_t cur;
  int gap = 0, burst_left = 0, drain_cnt = 0;
  always @(posedge clk) begin
    logic nxt_start, nxt_cfg;
    nxt_start = start;
    nxt_cfg = cfg_valid;
    if (rst) begin
      nxt_start = 0;
      nxt_cfg = 0;
    end else begin
      if (start && !busy) begin
        apply_request(cur);
        nxt_start = 0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cur.ri == REG_MODE) p_mode = mode_t'(cur.d[1:0]);
        else p_quantum = cur.d;
        nxt_cfg = 0;
      end
      if (!nxt_start && !nxt_cfg) begin
        if (gap > 0) begin
          gap--;
        end else if (pending_reqs.size() > 0) begin
          if (pending_reqs[0].kind == K_DRAIN) begin
            // hold until every report is in and the block is quiet
            if (expected_reports.size() == 0 && !busy) drain_cnt++;
            else drain_cnt = 0;
            if (drain_cnt >= 40) begin
              void'(pending_reqs.pop_front());
              drain_cnt = 0;
            end
          end else begin
            cur = pending_reqs.pop_front();
            if (cur.kind == K_CMD) begin
              nxt_start = 1;
              cmd <= cur.c;
              arrival <= cur.a;
              burst <= cur.b;
              prio <= cur.p;
            end else begin
              nxt_cfg = 1;
              cfg_index <= cur.ri;
              cfg_data <= cur.d;
            end
            if (burst_left > 0) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(1, 10);
              gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
          end
        end else begin
          stim_done <= 1;
        end
      end
    end
    start <= nxt_start;
    cfg_valid <= nxt_cfg;
  end

  // monitor
  always @(posedge clk) begin
    job_report_t e;
    if (!rst && strobe) begin
      n_reports++;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected report job %0d completion %0d", $time, job_index, completion);
        errors++;
      end else begin
        e = expected_reports.pop_front();
        if (job_index !== e.idx || completion !== e.comp || turnaround !== e.tat ||
            waiting !== e.wt || last !== e.lst) begin
          $display("%0t: mismatch exp idx %0d comp %0d tat %0d wait %0d last %0b", $time,
                   e.idx, e.comp, e.tat, e.wt, e.lst);
          $display("%0t:          got idx %0d comp %0d tat %0d wait %0d last %0b", $time,
                   job_index, completion, turnaround, waiting, last);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || strobe) wd <= 0;
    else wd <= wd + 1;
    if (wd >= WD_LIMIT) begin
      $display("%0t: timeout, %0d reports outstanding", $time, expected_reports.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void add_cmd(cmd_t c, int a, int b, int p);
    req_t r;
    r.kind = K_CMD;
    r.c = c;
    r.a = 16'(a);
    r.b = 8'(b);
    r.p = 8'(p);
    r.ri = REG_MODE;
    r.d = 0;
    pending_reqs = {pending_reqs, r};
  endfunction

  function automatic void add_cfg(reg_idx_t ri, int d);
    req_t r;
    r.kind = K_CFG;
    r.c = CMD_NONE;
    r.a = 0;
    r.b = 0;
    r.p = 0;
    r.ri = ri;
    r.d = 8'(d);
    pending_reqs = {pending_reqs, r};
  endfunction

  function automatic void add_drain();
    req_t r;
    r.kind = K_DRAIN;
    r.c = CMD_NONE;
    r.a = 0;
    r.b = 0;
    r.p = 0;
    r.ri = REG_MODE;
    r.d = 0;
    pending_reqs = {pending_reqs, r};
  endfunction

  initial begin
    int items, njobs, b;
    mode_t m;
    // directed: fcfs with idle CPU, zero burst, unused command, empty run
    add_cmd(CMD_RUN, 0, 0, 0);
    add_cmd(CMD_LOAD, 5, 3, 7);
    add_cmd(CMD_LOAD, 2, 0, 0);
    add_cmd(CMD_LOAD, 2, 4, 255);
    add_cmd(CMD_NONE, 65535, 255, 255);
    add_cmd(CMD_RUN, 0, 0, 0);
    add_drain();
    // priority mode, extreme fields
    add_cfg(REG_MODE, MODE_PRIO);
    add_cmd(CMD_LOAD, 65535, 255, 255);
    add_cmd(CMD_LOAD, 0, 1, 0);
    add_cmd(CMD_LOAD, 40000, 0, 0);
    add_cmd(CMD_RUN, 0, 0, 0);
    add_cmd(CMD_CLEAR, 0, 0, 0);
    add_cmd(CMD_RUN, 0, 0, 0);
    add_drain();
    // round robin with zero and largest quantum, arrivals during a slice
    add_cfg(REG_MODE, MODE_RR);
    add_cfg(REG_QUANTUM, 0);
    add_cmd(CMD_LOAD, 0, 5, 0);
    add_cmd(CMD_LOAD, 1, 3, 0);
    add_cmd(CMD_LOAD, 9, 2, 0);
    add_cmd(CMD_RUN, 0, 0, 0);
    add_drain();
    add_cfg(REG_QUANTUM, 255);
    add_cmd(CMD_RUN, 0, 0, 0);
    add_drain();
    // srtf with a full table and one load past it
    add_cfg(REG_MODE, MODE_SRTF);
    add_cfg(REG_QUANTUM, 3);
    add_cmd(CMD_CLEAR, 0, 0, 0);
    for (int k = 0; k <= NJ; k++) add_cmd(CMD_LOAD, k % 5, (k * 7) % 11, k);
    add_cmd(CMD_RUN, 0, 0, 0);
    items = 0;
    while (items < 130) begin
      add_drain();
      m = mode_t'($urandom_range(0, 3));
      add_cfg(REG_MODE, m);
      if ($urandom_range(0, 1)) add_cfg(REG_QUANTUM, $urandom_range(0, 6) == 0 ?
                                        $urandom_range(0, 255) : $urandom_range(1, 6));
      add_cmd(CMD_CLEAR, 0, 0, 0);
      njobs = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 7);
      for (int k = 0; k < njobs; k++) begin
        b = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
        add_cmd(CMD_LOAD, (m == MODE_PRIO) ? $urandom_range(0, 65535) : $urandom_range(0, 40),
                b, $urandom_range(0, 255));
        if ($urandom_range(0, 15) == 0) add_cmd(CMD_NONE, $urandom, $urandom, $urandom);
      end
      add_cmd(CMD_RUN, 0, 0, 0);
      items += njobs + 2;
      if ($urandom_range(0, 3) == 0) begin
        add_cmd(CMD_RUN, 0, 0, 0);
        items++;
      end
    end
    add_drain();
    repeat (12) @(posedge clk);
    rst <= 0;
    wait (stim_done);
    wait (expected_reports.size() == 0);
    repeat (50) @(posedge clk);
    $display("Ran %0d schedules over %0d job loads in all four modes; %0d reports checked.",
             n_runs, n_loads, n_reports);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
